>>> hw/rtl/y2r_pkg.sv
// types and constants shared by the yuyv to rgb24 converter
package y2r_pkg;

    localparam int unsigned PROD_W  = 16;
    localparam int unsigned DELTA_W = 10;

    localparam logic signed [PROD_W-1:0] COEF_RV = 16'sd104;
    localparam logic signed [PROD_W-1:0] COEF_GU = 16'sd89;
    localparam logic signed [PROD_W-1:0] COEF_GV = 16'sd183;
    localparam logic signed [PROD_W-1:0] COEF_BU = 16'sd199;

    localparam logic [7:0] CHANNEL_MAX = 8'd255;
    localparam logic [7:0] CHANNEL_MIN = 8'd0;

    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [DELTA_W-1:0] delta_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] chroma_blue;
        logic [7:0] luma_second;
        logic [7:0] chroma_red;
        logic       last_group;
    } yuyv_group_t;

    typedef struct packed {
        logic [7:0] red_first;
        logic [7:0] green_first;
        logic [7:0] blue_first;
        logic [7:0] red_second;
        logic [7:0] green_second;
        logic [7:0] blue_second;
        logic       frame_end;
    } rgb_pair_t;

    typedef struct packed {
        logic [7:0]       luma_first;
        logic [7:0]       luma_second;
        logic signed [7:0] chroma_u;
        logic signed [7:0] chroma_v;
        prod_t            prod_rv;
        prod_t            prod_gu;
        prod_t            prod_gv;
        prod_t            prod_bu;
        logic             last_group;
    } prod_stage_t;

    typedef struct packed {
        logic [7:0] luma_first;
        logic [7:0] luma_second;
        delta_t     delta_r;
        delta_t     delta_g;
        delta_t     delta_b;
        logic       last_group;
    } delta_stage_t;

endpackage

>>> hw/rtl/yuyv_to_rgb24_converter_unit.sv
// Converts one YUYV group per transfer into two RGB24 pixels sharing the chroma.
// The unit is a three-register pipeline: the first stage forms the chroma
// products, the second scales and sums them into per-channel offsets, the third
// adds each luma and saturates into the output register. A group passes through
// the product, offset and output registers, and one group is taken every
// cycle; a stall on m_ready fills empty stages first and then holds s_ready low.
// The last_group flag travels with its group and appears as frame_end.
module yuyv_to_rgb24_converter_unit (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  y2r_pkg::yuyv_group_t s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output y2r_pkg::rgb_pair_t   m_data
);
    import y2r_pkg::*;

    logic         prod_valid_reg;
    prod_stage_t  prod_reg;
    prod_stage_t  prod_next;
    logic         prod_ready;

    logic         delta_valid_reg;
    delta_stage_t delta_reg;
    delta_stage_t delta_next;
    logic         delta_ready;

    logic         out_valid_reg;
    rgb_pair_t    out_reg;
    rgb_pair_t    out_next;
    logic         out_ready;

    prod_t        u_ext;
    prod_t        v_ext;

    // ready chain, a stage moves when it is empty or its contents leave
    assign out_ready   = !out_valid_reg || m_ready;
    assign delta_ready = !delta_valid_reg || out_ready;
    assign prod_ready  = !prod_valid_reg || delta_ready;
    assign s_ready     = prod_ready;

    // stage one, chroma products
    always_comb begin
        prod_next             = prod_reg;
        prod_next.luma_first  = s_data.luma_first;
        prod_next.luma_second = s_data.luma_second;
        prod_next.chroma_u    = {~s_data.chroma_blue[7], s_data.chroma_blue[6:0]};
        prod_next.chroma_v    = {~s_data.chroma_red[7], s_data.chroma_red[6:0]};
        prod_next.last_group  = s_data.last_group;
    end

    assign u_ext = prod_t'(prod_next.chroma_u);
    assign v_ext = prod_t'(prod_next.chroma_v);

    prod_stage_t prod_full;

    always_comb begin
        prod_full         = prod_next;
        prod_full.prod_rv = prod_t'(v_ext * COEF_RV);
        prod_full.prod_gu = prod_t'(u_ext * COEF_GU);
        prod_full.prod_gv = prod_t'(v_ext * COEF_GV);
        prod_full.prod_bu = prod_t'(u_ext * COEF_BU);
    end

    // stage two, floor scaling and channel offsets
    always_comb begin
        delta_next             = delta_reg;
        delta_next.luma_first  = prod_reg.luma_first;
        delta_next.luma_second = prod_reg.luma_second;
        delta_next.last_group  = prod_reg.last_group;
        delta_next.delta_r     = delta_t'(prod_reg.chroma_v)
                               + delta_t'($signed(prod_reg.prod_rv[15:8]));
        delta_next.delta_g     = -delta_t'($signed(prod_reg.prod_gu[15:8]))
                               - delta_t'($signed(prod_reg.prod_gv[15:8]));
        delta_next.delta_b     = delta_t'(prod_reg.chroma_u)
                               + delta_t'($signed(prod_reg.prod_bu[15:8]));
    end

    // stage three, luma add and saturation
    y2r_clamp u_clamp_r0 (
        .luma    (delta_reg.luma_first),
        .delta   (delta_reg.delta_r),
        .channel (out_next.red_first)
    );
    y2r_clamp u_clamp_g0 (
        .luma    (delta_reg.luma_first),
        .delta   (delta_reg.delta_g),
        .channel (out_next.green_first)
    );
    y2r_clamp u_clamp_b0 (
        .luma    (delta_reg.luma_first),
        .delta   (delta_reg.delta_b),
        .channel (out_next.blue_first)
    );
    y2r_clamp u_clamp_r1 (
        .luma    (delta_reg.luma_second),
        .delta   (delta_reg.delta_r),
        .channel (out_next.red_second)
    );
    y2r_clamp u_clamp_g1 (
        .luma    (delta_reg.luma_second),
        .delta   (delta_reg.delta_g),
        .channel (out_next.green_second)
    );
    y2r_clamp u_clamp_b1 (
        .luma    (delta_reg.luma_second),
        .delta   (delta_reg.delta_b),
        .channel (out_next.blue_second)
    );
    assign out_next.frame_end = delta_reg.last_group;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_valid_reg  <= 1'b0;
            delta_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (prod_ready) begin
                prod_valid_reg <= s_valid;
            end
            if (delta_ready) begin
                delta_valid_reg <= prod_valid_reg;
            end
            if (out_ready) begin
                out_valid_reg <= delta_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (prod_ready && s_valid) begin
            prod_reg <= prod_full;
        end
        if (delta_ready && prod_valid_reg) begin
            delta_reg <= delta_next;
        end
        if (out_ready && delta_valid_reg) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // checks on the pipeline control
    a_ready_only_when_full: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (prod_valid_reg && delta_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled while the pipeline has room");

    a_stage_two_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (delta_valid_reg && out_valid_reg && !m_ready)
        |=> (delta_valid_reg && $stable(delta_reg)))
        else $error("stage two changed during a stall");

    a_result_from_stage_two: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(delta_valid_reg))
        else $error("result appeared with no group in stage two");

    a_transfer_enters_stage_one: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (prod_valid_reg
        && (prod_reg.last_group == $past(s_data.last_group))))
        else $error("accepted group missing from stage one");

endmodule

>>> hw/rtl/y2r_clamp.sv
// luma plus chroma offset with saturation to one 8-bit channel
module y2r_clamp (
    input  logic [7:0]      luma,
    input  y2r_pkg::delta_t delta,
    output logic [7:0]      channel
);
    import y2r_pkg::*;

    delta_t sum;

    assign sum = delta_t'({2'b00, luma}) + delta;

    always_comb begin
        priority if (sum[DELTA_W-1]) begin
            channel = CHANNEL_MIN;
        end else if (sum[DELTA_W-2]) begin
            channel = CHANNEL_MAX;
        end else begin
            channel = sum[7:0];
        end
    end

endmodule
